// ----- design/mraic_pkg.sv -----
// shared types, constants and helpers for the column-major index converter
// no dependencies
package mraic_pkg;

	localparam int MAX_DIMS  = 4;
	localparam int DIM_BITS  = 16;
	localparam int POS_BITS  = 32;
	localparam int DIV_STEPS = POS_BITS;
	// signed accumulator wide enough for the exact mixed-radix sum
	localparam int ACC_BITS  = MAX_DIMS * DIM_BITS + 2;
	localparam int DIDX_BITS = $clog2(MAX_DIMS);
	localparam int CNT_BITS  = 3;
	localparam int CIDX_BITS = 3;

	// register indexes of the configuration port
	typedef enum logic [CIDX_BITS-1:0] {
		REG_DIM_COUNT  = 3'd0,
		REG_DIM_SIZE_0 = 3'd1,
		REG_DIM_SIZE_1 = 3'd2,
		REG_DIM_SIZE_2 = 3'd3,
		REG_DIM_SIZE_3 = 3'd4
	} reg_idx_t;

	// request types
	localparam logic REQ_POS2IDX = 1'b0;
	localparam logic REQ_IDX2POS = 1'b1;

	// work carried from cell to cell
	typedef struct packed {
		logic                                req_type;
		logic [POS_BITS-1:0]                 num;
		logic [DIM_BITS-1:0]                 rem;
		logic [MAX_DIMS-1:0][DIM_BITS-1:0]   idx_in;
		logic [MAX_DIMS-1:0][DIM_BITS-1:0]   idx_out;
		logic signed [ACC_BITS-1:0]          acc;
	} work_t;

	// zero extent behaves as one
	function automatic logic [DIM_BITS-1:0] extent(input logic [DIM_BITS-1:0] s);
		return (s == '0) ? DIM_BITS'(1) : s;
	endfunction

endpackage

// ----- design/mraic_cell.sv -----
// one restoring division step: shifts one quotient bit into the working word
// depends on mraic_pkg
module mraic_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         v_in,
	input  mraic_pkg::work_t             p_in,
	input  logic [mraic_pkg::DIM_BITS-1:0] divisor,
	output logic                         v_q,
	output mraic_pkg::work_t             p_q
);
	import mraic_pkg::*;

	logic [DIM_BITS:0] trial;
	logic              ge;
	work_t             p_n;

	// compare and subtract
	always_comb begin
		trial = {p_in.rem, p_in.num[POS_BITS-1]};
		ge    = trial >= {1'b0, divisor};
		p_n   = p_in;
		p_n.rem = ge ? DIM_BITS'(trial - {1'b0, divisor}) : trial[DIM_BITS-1:0];
		p_n.num = {p_in.num[POS_BITS-2:0], ge};
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= v_in;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			p_q <= p_n;
		end
	end
endmodule

// ----- design/mraic_head.sv -----
// segment join: stores the finished index of the previous dimension and
// takes one Horner step of the index to position sum; depends on mraic_pkg
module mraic_head (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            v_in,
	input  mraic_pkg::work_t                p_in,
	input  logic [mraic_pkg::DIDX_BITS-1:0] hdim,
	input  logic                            hused,
	input  logic [mraic_pkg::DIM_BITS-1:0]  hext,
	input  logic [mraic_pkg::DIDX_BITS-1:0] wdim,
	input  logic                            wen,
	output logic                            v_q,
	output mraic_pkg::work_t                p_q
);
	import mraic_pkg::*;

	logic signed [ACC_BITS+DIM_BITS:0] prod;
	logic signed [DIM_BITS:0]          digit;
	work_t                             p_n;

	// horner step and index write-back
	always_comb begin
		prod  = p_in.acc * $signed({1'b0, hext});
		digit = (p_in.req_type == REQ_IDX2POS && hused)
			? $signed({1'b0, p_in.idx_in[hdim]}) - $signed((DIM_BITS+1)'(1))
			: '0;
		p_n     = p_in;
		p_n.acc = prod[ACC_BITS-1:0] + ACC_BITS'(digit);
		p_n.rem = '0;
		if (p_in.req_type == REQ_POS2IDX && wen) begin
			p_n.idx_out[wdim] = p_in.rem + DIM_BITS'(1);
		end
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= v_in;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			p_q <= p_n;
		end
	end
endmodule

// ----- design/mixed_radix_array_index_converter_core.sv -----
// Column-major index converter: position <-> one-based indices.
// Pipeline: 4 segments of one join stage and 32 division cells each, plus the
// output register. Throughput: one request per cycle; a stall at the output
// freezes the whole cell chain. Reset clears valid flags and loads the
// configuration with one dimension of extent one.
// depends on mraic_pkg, mraic_head, mraic_cell
module mixed_radix_array_index_converter_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mraic_pkg::CIDX_BITS-1:0]      cfg_index,
	input  logic [mraic_pkg::DIM_BITS-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic [mraic_pkg::POS_BITS-1:0]       position_in,
	input  logic [mraic_pkg::DIM_BITS-1:0]       index_in_0,
	input  logic [mraic_pkg::DIM_BITS-1:0]       index_in_1,
	input  logic [mraic_pkg::DIM_BITS-1:0]       index_in_2,
	input  logic [mraic_pkg::DIM_BITS-1:0]       index_in_3,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mraic_pkg::POS_BITS-1:0]       position_out,
	output logic [mraic_pkg::DIM_BITS-1:0]       index_out_0,
	output logic [mraic_pkg::DIM_BITS-1:0]       index_out_1,
	output logic [mraic_pkg::DIM_BITS-1:0]       index_out_2,
	output logic [mraic_pkg::DIM_BITS-1:0]       index_out_3,
	output logic                                 overflow
);
	import mraic_pkg::*;

	logic [CNT_BITS-1:0]               dim_count_q;
	logic [MAX_DIMS-1:0][DIM_BITS-1:0] dim_size_q;
	logic [MAX_DIMS-1:0][DIM_BITS-1:0] ext;
	logic [MAX_DIMS-1:0]               used;
	logic                              adv;
	work_t                             entry;

	logic  head_v [MAX_DIMS];
	work_t head_p [MAX_DIMS];
	logic  cell_v [MAX_DIMS][DIV_STEPS];
	work_t cell_p [MAX_DIMS][DIV_STEPS];
	work_t last_p;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= CNT_BITS'(1);
			dim_size_q  <= {MAX_DIMS{DIM_BITS'(1)}};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIM_COUNT:  dim_count_q   <= cfg_data[CNT_BITS-1:0];
				REG_DIM_SIZE_0: dim_size_q[0] <= cfg_data;
				REG_DIM_SIZE_1: dim_size_q[1] <= cfg_data;
				REG_DIM_SIZE_2: dim_size_q[2] <= cfg_data;
				REG_DIM_SIZE_3: dim_size_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective extents and dimensions in use
	always_comb begin
		for (int k = 0; k < MAX_DIMS; k++) begin
			ext[k]  = extent(dim_size_q[k]);
			used[k] = (k == 0) || (CNT_BITS'(k) < dim_count_q);
		end
	end

	// the whole chain advances unless a finished result is held
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// request entering the chain
	always_comb begin
		entry          = '0;
		entry.req_type = req_type;
		entry.num      = position_in;
		entry.idx_in   = {index_in_3, index_in_2, index_in_1, index_in_0};
	end

	// segments: dimension k is divided out while dimension 3-k joins the sum
	for (genvar k = 0; k < MAX_DIMS; k++) begin : g_seg
		mraic_head u_head (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.v_in   ((k == 0) ? in_valid : cell_v[(k == 0) ? 0 : k-1][DIV_STEPS-1]),
			.p_in   ((k == 0) ? entry : cell_p[(k == 0) ? 0 : k-1][DIV_STEPS-1]),
			.hdim   (DIDX_BITS'(MAX_DIMS-1-k)),
			.hused  (used[MAX_DIMS-1-k]),
			.hext   (ext[MAX_DIMS-1-k]),
			.wdim   (DIDX_BITS'((k == 0) ? 0 : k-1)),
			.wen    ((k != 0) && used[(k == 0) ? 0 : k-1]),
			.v_q    (head_v[k]),
			.p_q    (head_p[k])
		);
		for (genvar j = 0; j < DIV_STEPS; j++) begin : g_cell
			mraic_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.adv     (adv),
				.v_in    ((j == 0) ? head_v[k] : cell_v[k][(j == 0) ? 0 : j-1]),
				.p_in    ((j == 0) ? head_p[k] : cell_p[k][(j == 0) ? 0 : j-1]),
				.divisor (ext[k]),
				.v_q     (cell_v[k][j]),
				.p_q     (cell_p[k][j])
			);
		end
	end

	assign last_p = cell_p[MAX_DIMS-1][DIV_STEPS-1];

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= cell_v[MAX_DIMS-1][DIV_STEPS-1];
		end
	end

	// output register payload: last index or the wrapped position
	always_ff @(posedge clk) begin
		if (adv) begin
			if (last_p.req_type == REQ_POS2IDX) begin
				position_out <= '0;
				overflow     <= 1'b0;
				index_out_0  <= last_p.idx_out[0];
				index_out_1  <= last_p.idx_out[1];
				index_out_2  <= last_p.idx_out[2];
				index_out_3  <= used[MAX_DIMS-1] ? last_p.rem + DIM_BITS'(1) : '0;
			end else begin
				position_out <= last_p.acc[POS_BITS-1:0];
				overflow     <= last_p.acc[ACC_BITS-1:POS_BITS] != '0;
				index_out_0  <= '0;
				index_out_1  <= '0;
				index_out_2  <= '0;
				index_out_3  <= '0;
			end
		end
	end

	// overflow only comes from an index to position request
	a_ovf_no_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> index_out_0 == '0)
		else $error("overflow with index result");

	// an index result carries no position
	a_idx_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_out_0 != '0 |-> position_out == '0 && !overflow)
		else $error("index result with position");

	// higher dimensions are only filled when lower ones are
	a_dim_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_out_3 != '0 |-> index_out_2 != '0 && index_out_1 != '0)
		else $error("dimension gap in index result");

endmodule

// ----- tb/sv/mixed_radix_array_index_converter_core_tb.sv -----
// self-checking testbench for the column-major index converter core
// drives position and index requests with random idling, predicts every result
// depends on mraic_pkg and mixed_radix_array_index_converter_core
module mixed_radix_array_index_converter_core_tb;
	import mraic_pkg::*;

	localparam int LATENCY   = 133;
	localparam int WDOG_MAX  = 20000;
	localparam int HOLD_LONG = 400;

	typedef struct {
		logic        req_type;
		logic [31:0] position;
		logic [15:0] idx [4];
	} conv_req_t;

	typedef struct {
		logic [31:0] position;
		logic [15:0] idx [4];
		logic        overflow;
	} conv_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CIDX_BITS-1:0] cfg_index = '0;
	logic [DIM_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic [POS_BITS-1:0] position_in = '0;
	logic [DIM_BITS-1:0] index_in_0 = '0, index_in_1 = '0, index_in_2 = '0, index_in_3 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [POS_BITS-1:0] position_out;
	logic [DIM_BITS-1:0] index_out_0, index_out_1, index_out_2, index_out_3;
	logic overflow;

	mixed_radix_array_index_converter_core dut (.*);

	always #10 clk = ~clk;

	// shadow of the dimension registers
	logic [2:0]  sh_count;
	logic [15:0] sh_size [4];

	conv_req_t pending_reqs [$];
	conv_res_t expected_results [$];
	int n_errors = 0;
	int n_results = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_hold = 0;
	bit done_sending = 1'b0;

	// column-major conversion, exact arithmetic in 130 bits
	function automatic conv_res_t convert(conv_req_t r);
		conv_res_t res;
		int n;
		logic [129:0] below;
		logic signed [131:0] exact;
		logic [129:0] upto, rem;
		n = (sh_count == 0) ? 1 : ((sh_count > 4) ? 4 : sh_count);
		res.position = '0;
		res.overflow = 1'b0;
		for (int k = 0; k < 4; k++) res.idx[k] = '0;
		below = 1;
		exact = 0;
		for (int k = 0; k < n; k++) begin
			upto = below * ((sh_size[k] == 0) ? 130'd1 : 130'(sh_size[k]));
			if (r.req_type == REQ_POS2IDX) begin
				rem = 130'(r.position) % upto;
				res.idx[k] = 16'((rem / below) + 1);
			end else begin
				exact += $signed({2'b0, below}) * ($signed({1'b0, r.idx[k]}) - 1);
			end
			below = upto;
		end
		if (r.req_type == REQ_IDX2POS) begin
			res.position = exact[31:0];
			res.overflow = (exact < 0) || (exact > 132'sh0FFFFFFFF);
		end
		return res;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_DIM_COUNT) sh_count = val[2:0];
		else sh_size[int'(idx) - 1] = val;
	endtask

	task automatic set_dims(logic [2:0] cnt, logic [15:0] s0, logic [15:0] s1,
			logic [15:0] s2, logic [15:0] s3);
		write_reg(REG_DIM_COUNT, 16'(cnt));
		write_reg(REG_DIM_SIZE_0, s0);
		write_reg(REG_DIM_SIZE_1, s1);
		write_reg(REG_DIM_SIZE_2, s2);
		write_reg(REG_DIM_SIZE_3, s3);
	endtask

	// wait for the pipeline to drain, then a little more
	task automatic drain();
		wait (pending_reqs.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic push_req(logic t, logic [31:0] p, logic [15:0] a, logic [15:0] b,
			logic [15:0] c, logic [15:0] d);
		conv_req_t r;
		r.req_type = t;
		r.position = p;
		r.idx[0] = a; r.idx[1] = b; r.idx[2] = c; r.idx[3] = d;
		pending_reqs.push_back(r);
	endtask

	// random request, mostly in range of the current array
	task automatic push_random();
		logic [15:0] ix [4];
		logic [31:0] p;
		for (int k = 0; k < 4; k++) begin
			case ($urandom_range(0, 5))
				0: ix[k] = 16'($urandom);
				1: ix[k] = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'hFFFF;
				default: ix[k] = 16'($urandom_range(1, (sh_size[k] == 0) ? 1 : sh_size[k]));
			endcase
		end
		p = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 70000);
		push_req(1'($urandom), p, ix[0], ix[1], ix[2], ix[3]);
	endtask

	// request driver
	always @(posedge clk) begin
		conv_req_t r;
		if (arst_n && (!in_valid || !in_stall)) begin
			if (in_valid) expected_results.push_back(convert(pending_reqs.pop_front()));
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				r = pending_reqs[0];
				in_valid <= 1'b1;
				req_type <= r.req_type;
				position_in <= r.position;
				index_in_0 <= r.idx[0];
				index_in_1 <= r.idx[1];
				index_in_2 <= r.idx[2];
				index_in_3 <= r.idx[3];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk) begin
		conv_res_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_results.size() == 0) begin
					$error("result with nothing expected");
					n_errors++;
				end else begin
					e = expected_results.pop_front();
					if (position_out !== e.position) begin
						$error("position_out exp %h got %h", e.position, position_out);
						n_errors++;
					end
					if (index_out_0 !== e.idx[0]) begin
						$error("index_out_0 exp %h got %h", e.idx[0], index_out_0);
						n_errors++;
					end
					if (index_out_1 !== e.idx[1]) begin
						$error("index_out_1 exp %h got %h", e.idx[1], index_out_1);
						n_errors++;
					end
					if (index_out_2 !== e.idx[2]) begin
						$error("index_out_2 exp %h got %h", e.idx[2], index_out_2);
						n_errors++;
					end
					if (index_out_3 !== e.idx[3]) begin
						$error("index_out_3 exp %h got %h", e.idx[3], index_out_3);
						n_errors++;
					end
					if (overflow !== e.overflow) begin
						$error("overflow exp %b got %b", e.overflow, overflow);
						n_errors++;
					end
				end
			end
			if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no accepted request, result or configuration write
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| done_sending)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG_MAX) begin
			$display("mixed_radix_array_index_converter_core_tb: errors");
			$finish;
		end
	end

	initial begin
		sh_count = 3'd1;
		for (int k = 0; k < 4; k++) sh_size[k] = 16'd1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset configuration, then extremes and special cases
		push_req(REQ_POS2IDX, 32'd0, 0, 0, 0, 0);
		push_req(REQ_IDX2POS, 32'd0, 16'd1, 16'd1, 16'd1, 16'd1);
		drain();
		set_dims(3'd4, 16'd3, 16'd5, 16'd0, 16'd7);
		push_req(REQ_POS2IDX, 32'd0, 0, 0, 0, 0);
		push_req(REQ_POS2IDX, 32'd104, 0, 0, 0, 0);
		push_req(REQ_POS2IDX, 32'd105, 0, 0, 0, 0);
		push_req(REQ_POS2IDX, 32'hFFFFFFFF, 0, 0, 0, 0);
		push_req(REQ_IDX2POS, 32'hFFFFFFFF, 16'd3, 16'd5, 16'd1, 16'd7);
		push_req(REQ_IDX2POS, 32'd0, 16'd0, 16'd1, 16'd1, 16'd1);
		push_req(REQ_IDX2POS, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		drain();
		set_dims(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_req(REQ_POS2IDX, 32'hFFFFFFFF, 0, 0, 0, 0);
		push_req(REQ_POS2IDX, 32'h12345678, 0, 0, 0, 0);
		push_req(REQ_IDX2POS, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_req(REQ_IDX2POS, 32'd0, 16'd1, 16'd1, 16'd0, 16'd0);
		push_req(REQ_IDX2POS, 32'd0, 16'hFFFF, 16'h0001, 16'd1, 16'd1);
		drain();
		set_dims(3'd0, 16'hFFFF, 16'd2, 16'd2, 16'd2);
		push_req(REQ_POS2IDX, 32'd70000, 0, 0, 0, 0);
		push_req(REQ_IDX2POS, 32'd0, 16'hFFFF, 16'h5555, 16'hAAAA, 16'd9);
		drain();

		// random phases with several dimension settings and idling profiles
		for (int ph = 0; ph < 13; ph++) begin
			case (ph % 3)
				0: begin send_idle_pct = 23; recv_idle_pct = 74; end
				1: begin send_idle_pct = 74; recv_idle_pct = 23; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			if (ph == 12)
				set_dims(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
			else
				set_dims(3'($urandom_range(0, 7)), 16'($urandom_range(0, 300)),
					16'($urandom_range(0, 300)), 16'($urandom_range(0, 40)),
					($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9)));
			// long receiver hold with more requests than the chain can take
			if (ph == 2) begin
				recv_hold = HOLD_LONG;
				for (int i = 0; i < 200; i++) push_random();
			end else begin
				for (int i = 0; i < 100; i++) push_random();
			end
			drain();
		end
		done_sending = 1'b1;

		$display("covered directed extremes, zero extents and indices, counts 0..7,");
		$display("%0d results over 13 random phases with stalls and a long hold", n_results);
		if (n_errors == 0 && expected_results.size() == 0)
			$display("mixed_radix_array_index_converter_core_tb: clean");
		else
			$display("mixed_radix_array_index_converter_core_tb: errors");
		$finish;
	end

endmodule
